/* design/eapa_pkg.sv */
package eapa_pkg;

	localparam int WINDOW_LENGTH = 8;
	localparam int FULL_SCALE    = 16384;

	localparam int WORD_W   = 16;
	localparam int ANGLE_W  = 14;
	localparam int SAMPLE_W = $clog2(FULL_SCALE + 1);
	localparam int SUM_W    = $clog2(WINDOW_LENGTH * FULL_SCALE + 1);
	localparam int POS_W    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
	localparam int OUT_W    = 16;
	localparam int CFG_W    = 15;
	localparam int IDX_W    = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int QPTR_W   = $clog2(QUEUE_DEPTH);

	typedef enum logic [IDX_W-1:0] {
		REG_ANGLE_OFFSET      = 2'd0,
		REG_REVERSE_DIRECTION = 2'd1,
		REG_WRAP_MODULUS      = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [ANGLE_W-1:0]  raw_angle;
		logic                parity_error;
		logic [SAMPLE_W-1:0] sample;
	} queue_entry_t;

	typedef struct packed {
		logic [CFG_W-1:0] angle_offset;
		logic [CFG_W-1:0] wrap_modulus;
	} back_cfg_t;

endpackage

/* design/eapa_if.sv */
interface eapa_in_if;
	import eapa_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] sensor_word;
	modport source(output valid, output sensor_word, input ready);
	modport sink(input valid, input sensor_word, output ready);
endinterface

interface eapa_out_if;
	import eapa_pkg::*;
	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] raw_angle;
	logic               parity_error;
	logic [OUT_W-1:0]   filtered_angle;
	modport source(output valid, output raw_angle, output parity_error,
		output filtered_angle, input ready);
	modport sink(input valid, input raw_angle, input parity_error,
		input filtered_angle, output ready);
endinterface

interface eapa_cfg_if;
	import eapa_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [CFG_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

/* design/eapa_front.sv */
module eapa_front
	import eapa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	eapa_in_if.sink           din,
	eapa_cfg_if.sink          cfg,
	output logic              push_valid,
	input  logic              push_ready,
	output queue_entry_t      push_entry,
	output back_cfg_t         back_cfg
);

	logic [CFG_W-1:0]   angle_offset_q;
	logic               reverse_q;
	logic [CFG_W-1:0]   wrap_modulus_q;
	logic [ANGLE_W-1:0] angle;
	logic               cfg_wr;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_offset_q <= '0;
			reverse_q      <= 1'b0;
			wrap_modulus_q <= CFG_W'(FULL_SCALE);
		end else if (cfg_wr) begin
			unique case (cfg.index)
				REG_ANGLE_OFFSET: begin
					if (cfg.data <= wrap_modulus_q)
						angle_offset_q <= cfg.data;
				end
				REG_REVERSE_DIRECTION: reverse_q      <= cfg.data[0];
				REG_WRAP_MODULUS:      wrap_modulus_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign angle = din.sensor_word[ANGLE_W-1:0];

	always_comb begin
		push_entry.raw_angle    = angle;
		push_entry.parity_error = ^din.sensor_word;
		if (reverse_q)
			push_entry.sample = SAMPLE_W'(FULL_SCALE) - SAMPLE_W'(angle);
		else
			push_entry.sample = SAMPLE_W'(angle);
	end

	assign push_valid = din.valid;
	assign din.ready  = push_ready;

	assign back_cfg.angle_offset = angle_offset_q;
	assign back_cfg.wrap_modulus = wrap_modulus_q;

endmodule

/* design/eapa_queue.sv */
module eapa_queue
	import eapa_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  queue_entry_t push_entry,
	output logic         pop_valid,
	input  logic         pop_ready,
	output queue_entry_t pop_entry
);

	queue_entry_t        mem_q [QUEUE_DEPTH];
	logic [QCNT_W-1:0]   count_q;
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* design/eapa_back.sv */
module eapa_back
	import eapa_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  queue_entry_t pop_entry,
	input  back_cfg_t    back_cfg,
	eapa_out_if.source   dout
);

	logic [SAMPLE_W-1:0] window_q [WINDOW_LENGTH];
	logic [POS_W-1:0]    pos_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    sum_next;

	logic                valid_s1;
	logic [ANGLE_W-1:0]  raw_s1;
	logic                parity_s1;
	logic [SUM_W-1:0]    sum_s1;

	logic                out_valid_q;
	logic [ANGLE_W-1:0]  raw_q;
	logic                parity_q;
	logic [OUT_W-1:0]    filtered_q;

	logic                load_out;
	logic                load_s1;
	logic [SAMPLE_W-1:0] avg;
	logic [OUT_W-1:0]    value;
	logic [OUT_W-1:0]    wrap_ext;
	logic [OUT_W-1:0]    filtered;

	assign load_out  = valid_s1 && (!out_valid_q || dout.ready);
	assign pop_ready = !valid_s1 || load_out;
	assign load_s1   = pop_valid && pop_ready;

	assign sum_next = sum_q - SUM_W'(window_q[pos_q]) + SUM_W'(pop_entry.sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LENGTH; i++)
				window_q[i] <= '0;
			pos_q <= '0;
			sum_q <= '0;
		end else if (load_s1) begin
			window_q[pos_q] <= pop_entry.sample;
			pos_q <= (pos_q == POS_W'(WINDOW_LENGTH - 1)) ? '0 : pos_q + 1'b1;
			sum_q <= sum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1)
				valid_s1 <= 1'b1;
			else if (load_out)
				valid_s1 <= 1'b0;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (dout.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			raw_s1    <= pop_entry.raw_angle;
			parity_s1 <= pop_entry.parity_error;
			sum_s1    <= sum_next;
		end
		if (load_out) begin
			raw_q      <= raw_s1;
			parity_q   <= parity_s1;
			filtered_q <= filtered;
		end
	end

	assign avg      = SAMPLE_W'(sum_s1 / WINDOW_LENGTH);
	assign value    = OUT_W'(avg) + OUT_W'(back_cfg.angle_offset);
	assign wrap_ext = OUT_W'(back_cfg.wrap_modulus);

	always_comb begin
		if (value > OUT_W'(FULL_SCALE)) begin
			if (value >= wrap_ext)
				filtered = value - wrap_ext;
			else
				filtered = '0;
		end else begin
			filtered = value;
		end
	end

	assign dout.valid          = out_valid_q;
	assign dout.raw_angle      = raw_q;
	assign dout.parity_error   = parity_q;
	assign dout.filtered_angle = filtered_q;

endmodule

/* design/encoder_angle_parity_average_top.sv */
// A word taken on din goes through the queue, the s1 stage and the output register to dout.
// Throughput: one word per cycle unless dout stalls, set by the running-sum update.
// A two-entry queue separates the parity/reverse front from the window back end.
// Reset (arst_n low, asynchronous): window, sum and position cleared, config to
// reset values, all valids dropped; no clearing pass, words accepted at once.
module encoder_angle_parity_average_top
	import eapa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	eapa_in_if.sink    din,
	eapa_out_if.source dout,
	eapa_cfg_if.sink   cfg
);

	logic         push_valid;
	logic         push_ready;
	queue_entry_t push_entry;
	logic         pop_valid;
	logic         pop_ready;
	queue_entry_t pop_entry;
	back_cfg_t    back_cfg;

	eapa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.back_cfg   (back_cfg)
	);

	eapa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	eapa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.back_cfg  (back_cfg),
		.dout      (dout)
	);

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> pop_valid)
		else $error("transfer on din did not reach the queue");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!push_ready |-> pop_valid)
		else $error("queue full but reports empty");

	a_dout_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.ready |=> dout.valid && $stable(dout.filtered_angle))
		else $error("result changed while waiting on dout");

endmodule
